// File: src/wildcard_name_matcher_macros.svh
// Assertion macros used by the wildcard name matcher checker.
`ifndef WILDCARD_NAME_MATCHER_MACROS_SVH
`define WILDCARD_NAME_MATCHER_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is applied.
`define WNM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assertion whose consequent is checked in the cycle after the antecedent.
`define WNM_ASSERT_NEXT(label, ante, cons, msg) \
	`WNM_ASSERT(label, (ante) |=> (cons), msg)

`endif

// File: src/wnm_pkg.sv
// Package of the wildcard name matcher: sizes, request codes, characters and case folding.
package wnm_pkg;

	localparam int PATTERN_LEN = 32;
	localparam int COUNT_W     = $clog2(PATTERN_LEN + 1);
	localparam int LEVELS      = $clog2(PATTERN_LEN + 1);

	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_NAME   = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef logic [PATTERN_LEN:0]   pos_vec_t;
	typedef logic [PATTERN_LEN-1:0] pat_vec_t;

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// ASCII case folding; bytes outside A to Z pass unchanged.
	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] r;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end else begin
			r = c;
		end
		return r;
	endfunction

endpackage

// File: src/wnm_closure.sv
// Star closure of a set of live pattern positions as a log-depth prefix network.
module wnm_closure (
	input  wnm_pkg::pos_vec_t seed,
	input  wnm_pkg::pat_vec_t star,
	output wnm_pkg::pos_vec_t closed
);

	localparam int N = wnm_pkg::PATTERN_LEN;
	localparam int L = wnm_pkg::LEVELS;

	wnm_pkg::pos_vec_t s [0:L];
	wnm_pkg::pos_vec_t p [0:L];

	// A position j is reached from j-1 when position j-1 holds a star.
	always_comb begin
		s[0] = seed;
		p[0] = {star, 1'b0};
		for (int lv = 0; lv < L; lv++) begin
			for (int j = 0; j <= N; j++) begin
				if (j >= (1 << lv)) begin
					s[lv+1][j] = s[lv][j] | (s[lv][j-(1<<lv)] & p[lv][j]);
					p[lv+1][j] = p[lv][j] & p[lv][j-(1<<lv)];
				end else begin
					s[lv+1][j] = s[lv][j];
					p[lv+1][j] = p[lv][j];
				end
			end
		end
	end

	assign closed = s[L];

endmodule

// File: src/wildcard_name_matcher.sv
// A request is registered in the input stage, then processed; an end of name loads its result
// into the result register. One request per cycle while no end-of-name request is held up.
// A waiting result holds end-of-name requests; other requests flow past it while none is held.
// Reset (arst_n low, asynchronous) empties the pattern, clears the overflow flag and
// restarts the live set; the pattern bytes themselves are not cleared.
module wildcard_name_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_match,
	output logic       pattern_error
);

	localparam int N  = wnm_pkg::PATTERN_LEN;
	localparam int CW = wnm_pkg::COUNT_W;

	// Input register stage.
	logic           valid_s1;
	wnm_pkg::mode_t mode_s1;
	logic [7:0]     symbol_s1;

	// Pattern store, kept per position in decoded form so that every position can be
	// compared in parallel: a star flag, a question-mark flag and the folded byte.
	wnm_pkg::pat_vec_t star_q;
	wnm_pkg::pat_vec_t qmark_q;
	logic [7:0]        chr_q [N];

	// Control state.
	logic [CW-1:0]     count_q;
	logic              ovf_q;
	wnm_pkg::pos_vec_t live_q;   // live positions for the name in progress
	wnm_pkg::pos_vec_t start_q;  // position 0 and its star closure for the current pattern
	wnm_pkg::pos_vec_t tail_q;   // bit i: pattern from i onwards holds only dots and stars

	// Result register.
	logic out_valid_q;
	logic is_match_q;
	logic pattern_error_q;

	logic              out_free;
	logic              s1_go;
	logic              is_append;
	logic              is_end;
	logic              room;
	logic [7:0]        sym_fold;
	logic              sym_star;
	logic              sym_dotstar;
	wnm_pkg::pat_vec_t in_pat;
	wnm_pkg::pat_vec_t star_live;
	wnm_pkg::pat_vec_t wr_en;
	wnm_pkg::pos_vec_t upto;
	wnm_pkg::pos_vec_t step_vec;
	wnm_pkg::pos_vec_t next_live;
	wnm_pkg::pos_vec_t start_next;
	wnm_pkg::pos_vec_t tail_next;
	logic              hit;

	// An end-of-name request may only leave the input stage when the result register
	// can take its result; every other request leaves at once.
	assign out_free  = !out_valid_q || out_ready;
	assign is_end    = (mode_s1 == wnm_pkg::MODE_END);
	assign is_append = (mode_s1 == wnm_pkg::MODE_APPEND);
	assign s1_go     = valid_s1 && (!is_end || out_free);
	assign in_ready  = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1   <= wnm_pkg::mode_t'(mode);
			symbol_s1 <= symbol;
		end
	end

	assign sym_fold    = wnm_pkg::fold_char(symbol_s1);
	assign sym_star    = (symbol_s1 == wnm_pkg::CH_STAR);
	assign sym_dotstar = sym_star || (symbol_s1 == wnm_pkg::CH_DOT);
	assign room        = (count_q < CW'(N));

	// Position masks derived from the fill count: in_pat marks stored pattern bytes,
	// upto marks positions 0 to count inclusive.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			in_pat[i] = (CW'(i) < count_q);
			wr_en[i]  = s1_go && is_append && (CW'(i) == count_q);
		end
		for (int i = 0; i <= N; i++) begin
			upto[i] = (CW'(i) <= count_q);
		end
	end

	// One name character: a live star stays where it is, a live question mark or an
	// equal character moves one position on. Star closure then follows below.
	always_comb begin
		step_vec = '0;
		for (int i = 0; i < N; i++) begin
			if (live_q[i] && in_pat[i]) begin
				if (star_q[i]) begin
					step_vec[i] = 1'b1;
				end else if (qmark_q[i] || chr_q[i] == sym_fold) begin
					step_vec[i+1] = 1'b1;
				end
			end
		end
	end

	assign star_live = star_q & in_pat;

	wnm_closure u_closure (
		.seed   (step_vec),
		.star   (star_live),
		.closed (next_live)
	);

	// Appending a byte extends the start closure by one position when the start set
	// already reaches the new byte and that byte is a star. The tail flags of all
	// positions up to the new byte fold in whether it is a dot or a star.
	always_comb begin
		start_next = start_q;
		tail_next  = tail_q;
		for (int i = 0; i < N; i++) begin
			if (CW'(i) == count_q && start_q[i] && sym_star) begin
				start_next[i+1] = 1'b1;
			end
		end
		for (int i = 0; i <= N; i++) begin
			if (upto[i] && !sym_dotstar) begin
				tail_next[i] = 1'b0;
			end
		end
	end

	assign hit = |(live_q & tail_q & upto);

	// Pattern bytes are payload: written at the fill count, never cleared.
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			if (wr_en[i] && room) begin
				star_q[i]  <= sym_star;
				qmark_q[i] <= (symbol_s1 == wnm_pkg::CH_QUESTION);
				chr_q[i]   <= sym_fold;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			live_q  <= wnm_pkg::pos_vec_t'(1);
			start_q <= wnm_pkg::pos_vec_t'(1);
			tail_q  <= '1;
		end else if (s1_go) begin
			unique case (mode_s1)
				wnm_pkg::MODE_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					live_q  <= wnm_pkg::pos_vec_t'(1);
					start_q <= wnm_pkg::pos_vec_t'(1);
					tail_q  <= '1;
				end
				wnm_pkg::MODE_APPEND: begin
					// A full store drops the byte and raises the overflow flag; the
					// name in progress restarts either way.
					if (room) begin
						count_q <= count_q + CW'(1);
						start_q <= start_next;
						tail_q  <= tail_next;
						live_q  <= start_next;
					end else begin
						ovf_q  <= 1'b1;
						live_q <= start_q;
					end
				end
				wnm_pkg::MODE_NAME: begin
					live_q <= next_live;
				end
				wnm_pkg::MODE_END: begin
					live_q <= start_q;
				end
				default: begin
					live_q <= start_q;
				end
			endcase
		end
	end

	// Result register: loaded by an end of name, emptied when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && is_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && is_end) begin
			is_match_q      <= hit && !ovf_q;
			pattern_error_q <= ovf_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_match      = is_match_q;
	assign pattern_error = pattern_error_q;

endmodule

// File: src/wnm_checker.sv
// Port-level checker of the wildcard name matcher and its bind to the top level.
`include "wildcard_name_matcher_macros.svh"

module wnm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] mode,
	input logic [7:0] symbol,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_match,
	input logic       pattern_error
);

	// A stalled result stays offered.
	`WNM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A stalled result keeps its value.
	`WNM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(is_match) && $stable(pattern_error), "result changed while stalled")

	// An overflowed pattern never reports a match.
	`WNM_ASSERT(a_err_no_match, out_valid |-> !(is_match && pattern_error), "match reported with pattern error")

	// With no result waiting, the block always takes a request.
	`WNM_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "request refused with empty result register")

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.mode          (mode),
	.symbol        (symbol),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.is_match      (is_match),
	.pattern_error (pattern_error)
);

// File: tb/sv/tb.sv
// Self-checking testbench of the wildcard name matcher: a directed table, then random sessions.
`timescale 1ns / 100ps

module tb;
	import wnm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;
	localparam int PHASE_ITEMS = 412;
	localparam int MAX_GAP     = 12;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic is_match;
		logic pattern_error;
	} verdict_t;

	// One row of the directed table. Where typed is set, the verdict is the one written in
	// the row; otherwise it comes from the predictor.
	typedef struct packed {
		mode_t      m;
		logic [7:0] s;
		bit         typed;
		verdict_t   v;
	} stim_row_t;

	localparam int N_DIRECTED = 24;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{MODE_END,    8'h00,       1'b1, '{1'b1, 1'b0}},	// empty pattern, empty name
		'{MODE_NAME,   8'h61,       1'b0, '{1'b0, 1'b0}},
		'{MODE_END,    8'h00,       1'b1, '{1'b0, 1'b0}},	// empty pattern takes no byte
		'{MODE_APPEND, 8'h41,       1'b0, '{1'b0, 1'b0}},	// upper-case A
		'{MODE_NAME,   8'h61,       1'b0, '{1'b0, 1'b0}},	// lower-case a folds onto it
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}},
		'{MODE_CLEAR,  8'hFF,       1'b0, '{1'b0, 1'b0}},
		'{MODE_APPEND, CH_STAR,     1'b0, '{1'b0, 1'b0}},
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}},	// a star takes an empty name
		'{MODE_APPEND, CH_QUESTION, 1'b0, '{1'b0, 1'b0}},
		'{MODE_NAME,   8'hFF,       1'b0, '{1'b0, 1'b0}},
		'{MODE_NAME,   8'h00,       1'b0, '{1'b0, 1'b0}},
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}},
		'{MODE_APPEND, CH_DOT,      1'b0, '{1'b0, 1'b0}},
		'{MODE_NAME,   8'h78,       1'b0, '{1'b0, 1'b0}},
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}},	// trailing dot may be absent
		'{MODE_NAME,   8'h7A,       1'b0, '{1'b0, 1'b0}},
		'{MODE_APPEND, 8'h51,       1'b0, '{1'b0, 1'b0}},	// append drops the partial name
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}},
		'{MODE_CLEAR,  8'h00,       1'b0, '{1'b0, 1'b0}},
		'{MODE_APPEND, 8'hC1,       1'b0, '{1'b0, 1'b0}},
		'{MODE_NAME,   8'hE1,       1'b0, '{1'b0, 1'b0}},	// high bytes compare exactly
		'{MODE_END,    8'hFF,       1'b0, '{1'b0, 1'b0}},
		'{MODE_END,    8'h00,       1'b0, '{1'b0, 1'b0}}	// empty name straight after a result
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [1:0] mode      = MODE_CLEAR;
	logic [7:0] symbol    = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       is_match;
	logic       pattern_error;

	// The predictor's own copy of the matcher state.
	logic [7:0] pat_bytes [PATTERN_LEN];
	int         pat_len      = 0;
	bit         pat_overflow = 1'b0;
	pos_vec_t   live_set     = pos_vec_t'(1);

	verdict_t pending_verdicts [$];

	int requests_sent  = 0;
	int mismatch_count = 0;
	int idle_pct       = 0;
	int stall_pct      = 0;
	int cycle_count    = 0;

	wildcard_name_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.symbol        (symbol),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_match      (is_match),
		.pattern_error (pattern_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
	endfunction

	// Every position that a live star can skip over with an empty run is live as well.
	// Walking upwards lets a chain of stars propagate in one pass.
	function automatic pos_vec_t with_star_runs(input pos_vec_t v);
		pos_vec_t r;
		r = v;
		for (int i = 0; i < PATTERN_LEN; i++) begin
			if (i < pat_len && r[i] && pat_bytes[i] == CH_STAR) begin
				r[i+1] = 1'b1;
			end
		end
		return r;
	endfunction

	// Advances the predicted state by one accepted request; gives is set where the request
	// produces a verdict.
	task automatic predict_request(input mode_t m, input logic [7:0] s, output bit gives,
			output verdict_t v);
		pos_vec_t nxt;
		bit       hit;
		bit       clean;
		gives = 1'b0;
		v     = '0;
		nxt   = '0;
		hit   = 1'b0;
		case (m)
			MODE_CLEAR: begin
				pat_len      = 0;
				pat_overflow = 1'b0;
				live_set     = with_star_runs(pos_vec_t'(1));
			end
			MODE_APPEND: begin
				if (pat_len < PATTERN_LEN) begin
					pat_bytes[pat_len] = s;
					pat_len++;
				end else begin
					pat_overflow = 1'b1;
				end
				live_set = with_star_runs(pos_vec_t'(1));
			end
			MODE_NAME: begin
				for (int i = 0; i < PATTERN_LEN; i++) begin
					if (i < pat_len && live_set[i]) begin
						if (pat_bytes[i] == CH_STAR) begin
							nxt[i] = 1'b1;
						end else if (pat_bytes[i] == CH_QUESTION ||
								lower_ascii(pat_bytes[i]) == lower_ascii(s)) begin
							nxt[i+1] = 1'b1;
						end
					end
				end
				live_set = with_star_runs(nxt);
			end
			default: begin
				// A live position matches when what is left of the pattern is dots and stars.
				for (int i = 0; i <= PATTERN_LEN; i++) begin
					if (i <= pat_len && live_set[i]) begin
						clean = 1'b1;
						for (int j = i; j < PATTERN_LEN; j++) begin
							if (j < pat_len && pat_bytes[j] != CH_DOT && pat_bytes[j] != CH_STAR) begin
								clean = 1'b0;
							end
						end
						if (clean) begin
							hit = 1'b1;
						end
					end
				end
				v.is_match      = hit && !pat_overflow;
				v.pattern_error = pat_overflow;
				gives           = 1'b1;
				live_set        = with_star_runs(pos_vec_t'(1));
			end
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// Offers one request, after a random gap while the sender is idling, and returns at the
	// edge where it is accepted. The verdict it causes, if any, joins the queue there.
	task automatic send_request(input mode_t m, input logic [7:0] s, input bit typed,
			input verdict_t typed_v);
		int       gap;
		bit       gives;
		verdict_t v;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		symbol   <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests_sent++;
		predict_request(m, s, gives, v);
		if (gives) begin
			if (typed) begin
				v = typed_v;
			end
			pending_verdicts.push_back(v);
		end
	endtask

	// Holds the sender off until every expected verdict has been checked.
	task automatic settle_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	// Wildcards and letters a to d in either case, so that names built from a pattern often match.
	function automatic logic [7:0] random_pattern_char();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			return CH_STAR;
		end else if (pick < 35) begin
			return CH_QUESTION;
		end else if (pick < 45) begin
			return CH_DOT;
		end else if (pick < 85) begin
			return (8'h61 + 8'($urandom_range(3))) ^ ($urandom_range(1) ? CASE_OFFSET : 8'h00);
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] random_name_byte();
		if ($urandom_range(1)) begin
			return 8'h61 + 8'($urandom_range(3));
		end
		return 8'($urandom_range(255));
	endfunction

	// Either a short burst of noise, or a clear, a pattern and a few names built to follow it,
	// with occasional slips and the odd append in the middle of a name.
	task automatic run_random_session();
		logic [7:0] pat [$];
		logic [7:0] c;
		int         len;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(6, 1)) begin
				send_request(mode_t'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
			end
		end else begin
			send_request(MODE_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = $urandom_range(8);
			end else if (pick < 94) begin
				len = $urandom_range(PATTERN_LEN, 9);
			end else begin
				len = $urandom_range(PATTERN_LEN + 4, PATTERN_LEN + 1);
			end
			repeat (len) begin
				c = random_pattern_char();
				pat.push_back(c);
				send_request(MODE_APPEND, c, 1'b0, '0);
			end
			repeat ($urandom_range(4, 1)) begin
				foreach (pat[k]) begin
					pick = $urandom_range(99);
					if (pick < 3) begin
						// Skip this pattern element entirely.
					end else if (pick < 6) begin
						send_request(MODE_NAME, random_name_byte(), 1'b0, '0);
					end else if (pick < 8) begin
						send_request(MODE_APPEND, random_pattern_char(), 1'b0, '0);
					end else if (pat[k] == CH_STAR) begin
						repeat ($urandom_range(3)) begin
							send_request(MODE_NAME, random_name_byte(), 1'b0, '0);
						end
					end else if (pat[k] == CH_QUESTION) begin
						send_request(MODE_NAME, 8'($urandom_range(255)), 1'b0, '0);
					end else if (pat[k] == CH_DOT && $urandom_range(9) < 3) begin
						// Leave the dot out of the name; only harmless at the tail.
					end else begin
						c = pat[k];
						if (lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7A && $urandom_range(1)) begin
							c = c ^ CASE_OFFSET;
						end
						send_request(MODE_NAME, c, 1'b0, '0);
					end
				end
				if ($urandom_range(99) < 5) begin
					send_request(MODE_NAME, random_name_byte(), 1'b0, '0);
				end
				send_request(MODE_END, 8'($urandom_range(255)), 1'b0, '0);
			end
		end
	endtask

	// The receiver stalls at random and checks every accepted result against the oldest
	// expected verdict.
	always @(posedge clk) begin
		verdict_t want;
		out_ready <= arst_n && ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with no request waiting for one");
			end else begin
				want = pending_verdicts.pop_front();
				if (is_match !== want.is_match) begin
					report_mismatch($sformatf("is_match %b, expected %b", is_match, want.is_match));
				end
				if (pattern_error !== want.pattern_error) begin
					report_mismatch($sformatf("pattern_error %b, expected %b", pattern_error,
						want.pattern_error));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int phase_end;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			send_request(DIRECTED[r].m, DIRECTED[r].s, DIRECTED[r].typed, DIRECTED[r].v);
		end

		// Each phase starts with the sender held off until the queue is empty.
		for (int phase = 0; phase < 4; phase++) begin
			settle_results();
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 65;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 65;
				end
				default: begin
					idle_pct  = 20;
					stall_pct = 20;
				end
			endcase
			phase_end = requests_sent + PHASE_ITEMS;
			while (requests_sent < phase_end) begin
				run_random_session();
			end
		end

		settle_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			report_mismatch($sformatf("%0d expected results never arrived", pending_verdicts.size()));
		end
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
